// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg - shared types and constants for integer_to_ascii_radix
// Sizes for value width and digit buffer, radix and state codes, and the
// datapath command struct.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;

  // digit counts: decimal uses floor(w*log10(2)) + 1
  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int MAX_DIGITS = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;

  localparam int BUF_W = 4 * DEC_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_SIGN = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
  } cmd_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {3'b000, d};
    end else begin
      return CHAR_A + {3'b000, d} - {3'b000, DIGIT_TEN};
    end
  endfunction

endpackage

// File: rtl/itoa_digits.sv
// ----------------------------------------------------------------------------
// itoa_digits - bit-serial digit buffer
// Shifts the operand in one bit per cycle (shift-and-add-3 for decimal,
// plain shift for octal and hex), then shifts digits out top first.
// ----------------------------------------------------------------------------
module itoa_digits (
  input  logic                             clk,
  input  itoa_pkg::cmd_t                   cmd,
  input  itoa_pkg::radix_t                 radix,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0] load_val,
  output logic [3:0]                       digit
);

  logic [itoa_pkg::VALUE_WIDTH-1:0] sreg;
  logic [itoa_pkg::BUF_W-1:0]       buf_q;
  logic [itoa_pkg::BUF_W-1:0]       adj;
  itoa_pkg::radix_t                 rad;

  // add 3 to every BCD nibble >= 5 before the shift
  always_comb begin
    adj = buf_q;
    if (rad == itoa_pkg::RADIX_DEC) begin
      for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
        if (buf_q[4*i +: 4] >= 4'd5) begin
          adj[4*i +: 4] = buf_q[4*i +: 4] + 4'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sreg  <= load_val;
      buf_q <= '0;
      rad   <= radix;
    end else if (cmd.conv) begin
      buf_q <= {adj[itoa_pkg::BUF_W-2:0], sreg[itoa_pkg::VALUE_WIDTH-1]};
      sreg  <= {sreg[itoa_pkg::VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.emit) begin
      if (rad == itoa_pkg::RADIX_OCT) begin
        buf_q <= buf_q << 3;
      end else begin
        buf_q <= buf_q << 4;
      end
    end
  end

  always_comb begin
    case (rad)
      itoa_pkg::RADIX_DEC: digit = buf_q[4*itoa_pkg::DEC_DIGITS-1 -: 4];
      itoa_pkg::RADIX_OCT: digit = {1'b0, buf_q[3*itoa_pkg::OCT_DIGITS-1 -: 3]};
      default:             digit = buf_q[4*itoa_pkg::HEX_DIGITS-1 -: 4];
    endcase
  end

endmodule

// File: rtl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix - binary value to ASCII decimal, octal or hex text
// Steps: load, then the conversion, which shifts in the VALUE_WIDTH (32) bits
// one bit per cycle, then the sign, skipped leading zeros and emitted characters.
// Digit slots: 8 hex, 10 decimal plus sign, 11 octal. A new item is accepted
// only back in idle, after the last character of the previous one is loaded.
// Reset (synchronous, active high) returns the control to idle, holds off the
// input and empties the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [itoa_pkg::IN_W-1:0] value,
  input  logic [1:0]                base_select,
  input  logic                      is_signed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [6:0]                char_code,
  output logic                      last_char
);

  localparam int VW = itoa_pkg::VALUE_WIDTH;

  itoa_pkg::state_t              state, state_next;
  itoa_pkg::radix_t              rad_in;
  itoa_pkg::cmd_t                cmd;
  logic [itoa_pkg::BIT_W-1:0]    bit_cnt;
  logic [itoa_pkg::CNT_W-1:0]    dig_cnt;
  logic [itoa_pkg::CNT_W-1:0]    ndig_in;
  logic                          neg;
  logic                          neg_in;
  logic                          seen;
  logic [itoa_pkg::IN_W+VW-1:0]  val_ext;
  logic [VW-1:0]                 val_w;
  logic [VW-1:0]                 mag;
  logic [3:0]                    digit;
  logic                          out_free;
  logic                          load_out;
  logic [6:0]                    ch_next;
  logic                          last_next;

  assign val_ext = {{VW{1'b0}}, value};
  assign val_w   = val_ext[VW-1:0];

  always_comb begin
    case (base_select)
      itoa_pkg::RADIX_DEC: rad_in = itoa_pkg::RADIX_DEC;
      itoa_pkg::RADIX_OCT: rad_in = itoa_pkg::RADIX_OCT;
      default:             rad_in = itoa_pkg::RADIX_HEX;
    endcase
  end

  always_comb begin
    case (rad_in)
      itoa_pkg::RADIX_DEC: ndig_in = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
      itoa_pkg::RADIX_OCT: ndig_in = itoa_pkg::CNT_W'(itoa_pkg::OCT_DIGITS);
      default:             ndig_in = itoa_pkg::CNT_W'(itoa_pkg::HEX_DIGITS);
    endcase
  end

  assign neg_in   = is_signed && (rad_in == itoa_pkg::RADIX_DEC) && val_w[VW-1];
  assign mag      = neg_in ? ((~val_w) + {{(VW-1){1'b0}}, 1'b1}) : val_w;
  assign out_free = !out_valid || out_ready;

  itoa_digits u_digits (
    .clk      (clk),
    .cmd      (cmd),
    .radix    (rad_in),
    .load_val (mag),
    .digit    (digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    ch_next    = itoa_pkg::CHAR_MINUS;
    last_next  = 1'b0;
    case (state)
      itoa_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (bit_cnt == itoa_pkg::BIT_W'(1)) begin
          state_next = neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        ch_next   = itoa_pkg::digit_char(digit);
        last_next = (dig_cnt == itoa_pkg::CNT_W'(1));
        if (!seen && digit == 4'd0 && !last_next) begin
          cmd.emit = 1'b1;  // leading zero
        end else if (out_free) begin
          load_out = 1'b1;
          cmd.emit = 1'b1;
          if (last_next) begin
            state_next = itoa_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_cnt <= itoa_pkg::BIT_W'(VW);
      dig_cnt <= ndig_in;
      neg     <= neg_in;
      seen    <= 1'b0;
    end else begin
      if (cmd.conv) begin
        bit_cnt <= bit_cnt - itoa_pkg::BIT_W'(1);
      end
      if (cmd.emit) begin
        dig_cnt <= dig_cnt - itoa_pkg::CNT_W'(1);
      end
      if (load_out && state == itoa_pkg::ST_EMIT) begin
        seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      char_code <= ch_next;
      last_char <= last_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while a conversion is in progress");

  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    state == itoa_pkg::ST_EMIT |-> dig_cnt != '0)
    else $error("digit count exhausted during emission");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (char_code == itoa_pkg::CHAR_MINUS) ||
      (char_code >= itoa_pkg::CHAR_ZERO && char_code <= itoa_pkg::CHAR_ZERO + 7'd9) ||
      (char_code >= itoa_pkg::CHAR_A && char_code <= itoa_pkg::CHAR_A + 7'd5))
    else $error("output character outside sign and digit set");
`endif

endmodule

// File: sim/integer_to_ascii_radix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb - self-checking bench for the ASCII radix converter
// Drives values in decimal, octal and hex, signed and unsigned, first from a
// directed table, then at random. Each item is predicted as a text string and
// checked char by char, with the last-char mark, under varied idle patterns.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;

  localparam int         CLK_HALF      = 2;
  localparam int         ITEMS_PER_RUN = 40;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         DRAIN_CYCLES  = 60;
  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         DIRECTED_ROWS = 20;
  localparam string      DIGIT_SET     = "0123456789ABCDEF";
  localparam logic [1:0] SEL_UNUSED    = 2'd3;

  typedef enum int {
    PH_FLOW,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    logic [itoa_pkg::IN_W-1:0] v;
    logic [1:0]                sel;
    logic                      sgn;
    string                     txt;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [itoa_pkg::IN_W-1:0] value = '0;
  logic [1:0]                base_select = itoa_pkg::RADIX_DEC;
  logic                      is_signed = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [6:0]                char_code;
  logic                      last_char;

  phase_t     phase_id = PH_FLOW;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         mismatch_cnt = 0;
  string      pending_texts[$];
  text_char_t expected_chars[$];

  // typed text only where it is plain to see; the rest goes to the predictor
  dir_row_t dir_rows [DIRECTED_ROWS] = '{
    '{32'h0000_0000, itoa_pkg::RADIX_DEC, 1'b0, "0"},
    '{32'h0000_0000, itoa_pkg::RADIX_OCT, 1'b1, "0"},
    '{32'h0000_0000, itoa_pkg::RADIX_HEX, 1'b0, "0"},
    '{32'h0000_0009, itoa_pkg::RADIX_DEC, 1'b1, "9"},
    '{32'h0000_0008, itoa_pkg::RADIX_OCT, 1'b0, "10"},
    '{32'h0000_000A, itoa_pkg::RADIX_HEX, 1'b1, "A"},
    '{32'hFFFF_FFFF, itoa_pkg::RADIX_DEC, 1'b0, "4294967295"},
    '{32'hFFFF_FFFF, itoa_pkg::RADIX_DEC, 1'b1, "-1"},
    '{32'h8000_0000, itoa_pkg::RADIX_DEC, 1'b1, "-2147483648"},
    '{32'h8000_0000, itoa_pkg::RADIX_DEC, 1'b0, "2147483648"},
    '{32'h7FFF_FFFF, itoa_pkg::RADIX_DEC, 1'b1, "2147483647"},
    '{32'hFFFF_FFFF, itoa_pkg::RADIX_OCT, 1'b0, "37777777777"},
    '{32'hFFFF_FFFF, itoa_pkg::RADIX_OCT, 1'b1, "37777777777"},
    '{32'hFFFF_FFFF, itoa_pkg::RADIX_HEX, 1'b1, "FFFFFFFF"},
    '{32'h00AB_CDEF, itoa_pkg::RADIX_HEX, 1'b0, "ABCDEF"},
    '{32'hFFFF_FFF0, SEL_UNUSED, 1'b1, "FFFFFFF0"},
    '{32'h1234_5678, itoa_pkg::RADIX_DEC, 1'b1, ""},
    '{32'h8000_0001, itoa_pkg::RADIX_OCT, 1'b1, ""},
    '{32'hDEAD_BEEF, itoa_pkg::RADIX_DEC, 1'b1, ""},
    '{32'h0000_1000, SEL_UNUSED, 1'b0, ""}
  };

  integer_to_ascii_radix u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .base_select (base_select),
    .is_signed   (is_signed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .last_char   (last_char)
  );

  always #CLK_HALF clk = ~clk;

  function automatic string radix_text(logic [itoa_pkg::IN_W-1:0] v, logic [1:0] sel,
                                       logic sgn);
    logic [63:0] mag;
    logic [63:0] mask;
    int unsigned base;
    bit          neg;
    string       txt;
    int          d;
    mask = (64'd1 << itoa_pkg::VALUE_WIDTH) - 64'd1;
    mag  = 64'(v) & mask;
    if (sel == itoa_pkg::RADIX_DEC) begin
      base = 10;
    end else if (sel == itoa_pkg::RADIX_OCT) begin
      base = 8;
    end else begin
      base = 16;
    end
    neg = sgn && (sel == itoa_pkg::RADIX_DEC) && mag[itoa_pkg::VALUE_WIDTH-1];
    if (neg) begin
      mag = (~mag + 64'd1) & mask;
    end
    txt = "";
    do begin
      d   = int'(mag % base);
      txt = {DIGIT_SET.substr(d, d), txt};
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      txt = {"-", txt};
    end
    return txt;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin : char_check
    string      txt;
    text_char_t exp_c;
    byte        ch;
    if (!rst) begin
      if (in_valid && in_ready) begin
        txt = (pending_texts.size() != 0) ? pending_texts.pop_front() : "";
        if (txt.len() == 0) begin
          txt = radix_text(value, base_select, is_signed);
        end
        for (int i = 0; i < txt.len(); i++) begin
          ch = txt[i];
          expected_chars.push_back('{ch[6:0], i == txt.len() - 1});
        end
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected char %h last %b", char_code, last_char));
        end else begin
          exp_c = expected_chars.pop_front();
          if (char_code !== exp_c.code || last_char !== exp_c.last) begin
            flag_mismatch($sformatf("char exp %h last %b, got %h last %b",
                                    exp_c.code, exp_c.last, char_code, last_char));
          end
        end
      end
    end
  end

  // output side; one long hold-off when the pressure phase opens
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (phase_id == PH_PRESSURE && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_item(logic [itoa_pkg::IN_W-1:0] v, logic [1:0] sel, logic sgn,
                           string txt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    value       <= v;
    base_select <= sel;
    is_signed   <= sgn;
    in_valid    <= 1'b1;
    pending_texts.push_back(txt);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_item();
    logic [itoa_pkg::IN_W-1:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom_range(99);
      2: v = $urandom >> $urandom_range(31);
      3: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h0000_0000;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = -32'($urandom_range(999));
    endcase
    send_item(v, 2'($urandom_range(3)), 1'($urandom_range(1)), "");
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(dir_rows[i].v, dir_rows[i].sel, dir_rows[i].sgn, dir_rows[i].txt);
    end

    for (int p = PH_FLOW; p <= PH_PRESSURE; p++) begin
      phase_id = phase_t'(p);
      case (phase_id)
        PH_FLOW:       begin send_idle_pct = 0;  stall_pct = 0;  end
        PH_SEND_IDLE:  begin send_idle_pct = 65; stall_pct = 0;  end
        PH_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 65; end
        PH_BOTH:       begin send_idle_pct = 38; stall_pct = 38; end
        default:       begin send_idle_pct = 0;  stall_pct = 20; end
      endcase
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        send_random_item();
      end
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0 || pending_texts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/itoa_pkg.sv
rtl/itoa_digits.sv
rtl/integer_to_ascii_radix.sv
sim/integer_to_ascii_radix_tb.sv
